// ----- rtl/core/gop_picture_type_and_refs_core_defines.svh -----
// Assertion macros shared by the GOP planner checker.
// No dependencies; included by bare file name.
`ifndef GOP_PICTURE_TYPE_AND_REFS_CORE_DEFINES_SVH
`define GOP_PICTURE_TYPE_AND_REFS_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define GOPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gopr check failed");

// next-cycle implication, masked during reset
`define GOPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gopr check failed");

// next-cycle implication, active through reset
`define GOPR_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gopr check failed");

`endif

// ----- rtl/core/gopr_pkg.sv -----
// Shared types and codes for the GOP planner.
// No dependencies.
package gopr_pkg;

  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_MAP      = 1'b1;

  localparam logic [1:0] SORT_INTRA_REF    = 2'd0;
  localparam logic [1:0] SORT_INTRA_NONREF = 2'd1;
  localparam logic [1:0] SORT_INTER_REF    = 2'd2;
  localparam logic [1:0] SORT_INTER_NONREF = 2'd3;

  localparam logic [1:0] REG_GOP_LENGTH = 2'd0;
  localparam logic [1:0] REG_L1_SPACING = 2'd1;
  localparam logic [1:0] REG_L1_ENABLED = 2'd2;
  localparam logic [1:0] REG_FIELD_MODE = 2'd3;

  localparam int GOP_W  = 10;
  localparam int L1_W   = 8;
  localparam int UNIT_W = 11;
  localparam int EXP_W  = 11;
  localparam int NUM_W  = 32;

  typedef struct packed {
    logic              cmd;
    logic [1:0]        picture_sort;
    logic [1:0]        ref_count;
    logic [NUM_W-1:0]  ref_first;
    logic [NUM_W-1:0]  ref_second;
    logic [EXP_W-1:0]  expiry_time;
    logic [NUM_W-1:0]  display_number;
  } cls_t;

endpackage

// ----- rtl/core/gopr_ifs.sv -----
// Valid/ready channel interfaces for the GOP planner.
// Depends on nothing; fields at fixed widths.
interface gopr_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] picture_number;
  logic        forward_ref_available;
  modport source (output valid, cmd, picture_number, forward_ref_available, input ready);
  modport sink   (input valid, cmd, picture_number, forward_ref_available, output ready);
endinterface

interface gopr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  picture_sort;
  logic [1:0]  ref_count;
  logic [31:0] ref_first;
  logic [31:0] ref_second;
  logic [10:0] expiry_time;
  logic [31:0] display_number;
  logic        new_access_unit;
  modport source (output valid, picture_sort, ref_count, ref_first, ref_second,
                  expiry_time, display_number, new_access_unit, input ready);
  modport sink   (input valid, picture_sort, ref_count, ref_first, ref_second,
                  expiry_time, display_number, new_access_unit, output ready);
endinterface

// ----- rtl/core/gop_picture_type_and_refs_core.sv -----
// GOP planner: two 4-bit-per-stage divider pipelines in series plus input,
// decision and output registers. Throughput one transaction per cycle; a
// stall freezes all stages. Synchronous reset clears valid bits and loads
// register defaults.
module gop_picture_type_and_refs_core #(
  parameter int PICNUM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  gopr_req_if.sink    req,
  gopr_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  localparam int N     = PICNUM_BITS;
  localparam int STEPS = 4;
  localparam int LAT   = (N + STEPS - 1) / STEPS;

  logic [9:0] gop_length;
  logic [7:0] l1_spacing;
  logic       l1_enabled;
  logic       field_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      gop_length <= 10'd1;
      l1_spacing <= 8'd0;
      l1_enabled <= 1'b0;
      field_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gopr_pkg::REG_GOP_LENGTH: gop_length <= cfg_data;
        gopr_pkg::REG_L1_SPACING: l1_spacing <= cfg_data[7:0];
        gopr_pkg::REG_L1_ENABLED: l1_enabled <= cfg_data[0];
        gopr_pkg::REG_FIELD_MODE: field_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [9:0]  gop;
  logic [10:0] unit;
  assign gop  = (gop_length == '0) ? 10'd1 : gop_length;
  assign unit = field_mode ? {gop, 1'b0} : {1'b0, gop};

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // input stage
  logic         v0;
  logic         cmd0, fwd0;
  logic [N-1:0] p0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= req.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd0 <= req.cmd;
      fwd0 <= req.forward_ref_available;
      p0   <= req.picture_number[N-1:0];
    end
  end

  logic [N-1:0] x0, num_l;
  assign x0    = field_mode ? {1'b0, p0[N-1:1]} : p0;
  assign num_l = (cmd0 == gopr_pkg::CMD_MAP) ? x0 - N'(1) : x0;

  logic [N-1:0] quo_g, quo_l;
  logic [9:0]   rem_g;
  logic [7:0]   rem_l;

  gopr_divpipe #(.W(N), .DW(10), .STEPS(STEPS)) u_div_gop (
    .clk(clk), .en(en), .num(x0), .den(gop), .quo(quo_g), .rem(rem_g));
  gopr_divpipe #(.W(N), .DW(8), .STEPS(STEPS)) u_div_l1 (
    .clk(clk), .en(en), .num(num_l), .den(l1_spacing), .quo(quo_l), .rem(rem_l));

  // sideband for the first division
  logic [N+1:0] sa [LAT];
  logic [LAT-1:0] va;
  always_ff @(posedge clk) begin
    if (rst) va <= '0;
    else if (en) va <= {va[LAT-2:0], v0};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= {cmd0, fwd0, p0};
      for (int i = 1; i < LAT; i++) sa[i] <= sa[i-1];
    end
  end

  gopr_pkg::cls_t dec;
  gopr_decide #(.N(N)) u_decide (
    .cmd(sa[LAT-1][N+1]), .p(sa[LAT-1][N-1:0]), .fwd(sa[LAT-1][N]),
    .field(field_mode), .l1_en(l1_enabled), .l1(l1_spacing), .gop(gop),
    .rem_g(rem_g), .rem_l(rem_l), .quo_l(quo_l), .res(dec));

  // decision register
  logic           v1;
  gopr_pkg::cls_t r1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= va[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) r1 <= dec;
  end

  logic [N-1:0]  quo_u;
  logic [10:0]   rem_u;
  gopr_divpipe #(.W(N), .DW(11), .STEPS(STEPS)) u_div_unit (
    .clk(clk), .en(en), .num(r1.display_number[N-1:0]), .den(unit),
    .quo(quo_u), .rem(rem_u));

  gopr_pkg::cls_t sb [LAT];
  logic [LAT-1:0] vb;
  always_ff @(posedge clk) begin
    if (rst) vb <= '0;
    else if (en) vb <= {vb[LAT-2:0], v1};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= r1;
      for (int i = 1; i < LAT; i++) sb[i] <= sb[i-1];
    end
  end

  // output register
  logic           vo;
  gopr_pkg::cls_t ro;
  logic           nau;
  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (en) vo <= vb[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ro  <= sb[LAT-1];
      nau <= (sb[LAT-1].cmd == gopr_pkg::CMD_MAP) && (rem_u == '0);
    end
  end

  assign rsp.valid           = vo;
  assign rsp.picture_sort    = ro.picture_sort;
  assign rsp.ref_count       = ro.ref_count;
  assign rsp.ref_first       = ro.ref_first;
  assign rsp.ref_second      = ro.ref_second;
  assign rsp.expiry_time     = ro.expiry_time;
  assign rsp.display_number  = ro.display_number;
  assign rsp.new_access_unit = nau;

  logic unused_q;
  assign unused_q = ^{quo_g, quo_u};
endmodule

// ----- rtl/core/gopr_divpipe.sv -----
// Pipelined restoring divider, STEPS quotient bits per stage.
// Standalone; divisor must hold steady while operands are in flight.
module gopr_divpipe #(
  parameter int W     = 32,
  parameter int DW    = 8,
  parameter int STEPS = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num,
  input  logic [DW-1:0] den,
  output logic [W-1:0]  quo,
  output logic [DW-1:0] rem
);
  localparam int STAGES = (W + STEPS - 1) / STEPS;
  localparam int WP     = STAGES * STEPS;

  logic [WP-1:0] a_q [STAGES];
  logic [DW-1:0] r_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [WP-1:0] a_next;
    logic [DW-1:0] r_next;

    always_comb begin
      logic [WP-1:0] a;
      logic [DW-1:0] r;
      logic [DW:0]   r2;
      logic          ge;
      if (s == 0) begin
        a = WP'(num);
        r = '0;
      end else begin
        a = a_q[(s == 0) ? 0 : s - 1];
        r = r_q[(s == 0) ? 0 : s - 1];
      end
      for (int k = 0; k < STEPS; k++) begin
        r2 = {r, a[WP-1]};
        ge = (r2 >= {1'b0, den});
        a  = {a[WP-2:0], ge};
        r  = ge ? DW'(r2 - {1'b0, den}) : r2[DW-1:0];
      end
      a_next = a;
      r_next = r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[s] <= a_next;
        r_q[s] <= r_next;
      end
    end
  end

  assign quo = a_q[STAGES-1][W-1:0];
  assign rem = r_q[STAGES-1];
endmodule

// ----- rtl/core/gopr_decide.sv -----
// Picture classification and coding-to-display mapping from remainders.
// Depends on gopr_pkg.
module gopr_decide #(
  parameter int N = 32
) (
  input  logic                    cmd,
  input  logic [N-1:0]            p,
  input  logic                    fwd,
  input  logic                    field,
  input  logic                    l1_en,
  input  logic [gopr_pkg::L1_W-1:0]  l1,
  input  logic [gopr_pkg::GOP_W-1:0] gop,
  input  logic [gopr_pkg::GOP_W-1:0] rem_g,
  input  logic [gopr_pkg::L1_W-1:0]  rem_l,
  input  logic [N-1:0]            quo_l,
  output gopr_pkg::cls_t          res
);
  logic [N-1:0] x, l1n, gopn, nxt_l1, d;
  logic         par;
  logic [1:0]   sort, cnt;
  logic [N-1:0] r0, r1;
  logic [gopr_pkg::EXP_W-1:0] ex;
  logic         at_gop, at_l1, at_last;

  assign par     = p[0];
  assign x       = field ? {1'b0, p[N-1:1]} : p;
  assign l1n     = N'(l1);
  assign gopn    = N'(gop);
  assign nxt_l1  = N'((quo_l + N'(1)) * l1n);
  assign at_gop  = (rem_g == '0);
  assign at_l1   = (rem_l == '0);
  assign at_last = (rem_l == l1 - 8'd1);

  always_comb begin
    sort = gopr_pkg::SORT_INTRA_NONREF;
    cnt  = 2'd0;
    r0   = '0;
    r1   = '0;
    ex   = field ? 11'd2 : 11'd1;
    if (!l1_en || l1 == '0) begin
      sort = gopr_pkg::SORT_INTRA_NONREF;
    end else if (!field) begin
      if (at_gop) begin
        sort = (gop > 10'd1) ? gopr_pkg::SORT_INTRA_REF : gopr_pkg::SORT_INTRA_NONREF;
        ex   = 11'(gop);
      end else if (at_l1) begin
        sort = gopr_pkg::SORT_INTER_REF; cnt = 2'd1; r0 = p - l1n;
        ex   = {2'b0, l1, 1'b0};
      end else if (at_last) begin
        sort = gopr_pkg::SORT_INTER_NONREF; cnt = 2'd1; r0 = p - N'(1);
        if (fwd) begin cnt = 2'd2; r1 = p + N'(1); end
        ex   = 11'd1;
      end else begin
        sort = gopr_pkg::SORT_INTER_REF; cnt = 2'd1; r0 = p - N'(1);
        if (fwd) begin cnt = 2'd2; r1 = nxt_l1; end
        ex   = 11'd2;
      end
    end else begin
      if (at_gop) begin
        if (gop > 10'd1) begin
          sort = gopr_pkg::SORT_INTRA_REF;
          ex   = {gop, 1'b0};
          if (par) begin sort = gopr_pkg::SORT_INTER_REF; cnt = 2'd1; r0 = p - N'(1); end
        end else begin
          sort = gopr_pkg::SORT_INTRA_NONREF;
          ex   = 11'(gop);
        end
      end else if (at_l1) begin
        sort = gopr_pkg::SORT_INTER_REF; cnt = 2'd2;
        if (par) begin
          r0 = p - N'(1);
          r1 = p - (l1n << 1);
        end else begin
          r0 = p - (l1n << 1);
          r1 = p - (l1n << 1) + N'(1);
        end
        ex = 11'({2'b0, l1, 1'b0} + 11'd1);
      end else if (at_last) begin
        sort = gopr_pkg::SORT_INTER_NONREF; cnt = 2'd1; r0 = p - N'(2);
        if (fwd) begin cnt = 2'd2; r1 = p + N'(2); end
        ex   = 11'd1;
      end else begin
        sort = gopr_pkg::SORT_INTER_REF; cnt = 2'd1; r0 = p - N'(2);
        if (fwd) begin cnt = 2'd2; r1 = {nxt_l1[N-2:0], par}; end
        ex   = 11'd4;
      end
    end
  end

  // map: rem_l/quo_l here come from (x - 1) divided by the spacing
  always_comb begin
    if (l1 == '0) begin
      d = p;
    end else if (x == '0) begin
      d = p;
    end else if (at_l1) begin
      d = field ? p + ((l1n - N'(1)) << 1) : p + l1n - N'(1);
    end else begin
      d = field ? p - N'(2) : p - N'(1);
    end
  end

  always_comb begin
    res = '0;
    res.cmd = cmd;
    if (cmd == gopr_pkg::CMD_CLASSIFY) begin
      res.picture_sort = sort;
      res.ref_count    = cnt;
      res.ref_first    = gopr_pkg::NUM_W'(r0);
      res.ref_second   = gopr_pkg::NUM_W'(r1);
      res.expiry_time  = ex;
    end else begin
      res.display_number = gopr_pkg::NUM_W'(d);
    end
  end

  logic unused_gopn;
  assign unused_gopn = ^gopn;
endmodule

// ----- rtl/core/gopr_checker.sv -----
// Port-level checks for the GOP planner, bound to the top level.
// Depends on gop_picture_type_and_refs_core_defines.svh.
`include "gop_picture_type_and_refs_core_defines.svh"

module gopr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] ref_count
);
`GOPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
`GOPR_ASSERT_NOW(a_ready_free, !out_valid, in_ready)
`GOPR_ASSERT_ALWAYS(a_reset_idle, rst, !out_valid)
`GOPR_ASSERT_NOW(a_ref_count, out_valid, ref_count != 2'd3)

  logic unused_in;
  assign unused_in = in_valid;
endmodule

bind gop_picture_type_and_refs_core gopr_checker u_gopr_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .ref_count(rsp.ref_count));

// ----- sim/tb_gop_picture_type_and_refs_core.sv -----
// Testbench for the GOP planner core: random and directed classify and map
// transactions, checked against an in-bench prediction of each result.
// Depends on gopr_pkg and the gopr_req_if / gopr_rsp_if interfaces.
module tb_gop_picture_type_and_refs_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        cmd;
    logic [31:0] num;
    logic        fwd;
  } pic_req_t;

  typedef struct {
    logic [1:0]  sort;
    logic [1:0]  cnt;
    logic [31:0] ref0;
    logic [31:0] ref1;
    logic [10:0] expiry;
    logic [31:0] disp;
    logic        nau;
  } plan_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  gopr_req_if req ();
  gopr_rsp_if rsp ();

  gop_picture_type_and_refs_core DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pic_req_t pic_queue[$];
  plan_t    plan_queue[$];
  int unsigned gop_len, l1_sp, l1_en, fld_mode;
  int unsigned send_idle_pct, stall_pct, hold_cycles;
  logic hold_go, hold_done;
  int errors;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic plan_t plan_picture(pic_req_t t);
    plan_t o;
    longint unsigned p, gop, l1, f, par, d, unit;
    o = '{default: '0};
    p = 64'(t.num);
    gop = (gop_len == 0) ? 64'd1 : 64'(gop_len);
    l1 = 64'(l1_sp);
    f = p >> 1;
    par = p & 64'd1;
    if (t.cmd == gopr_pkg::CMD_CLASSIFY) begin
      if (l1_en == 0 || l1 == 0) begin
        o.sort = gopr_pkg::SORT_INTRA_NONREF;
        o.expiry = (fld_mode != 0) ? 11'd2 : 11'd1;
      end else if (fld_mode == 0) begin
        if (p % gop == 0) begin
          o.sort = (gop > 1) ? gopr_pkg::SORT_INTRA_REF : gopr_pkg::SORT_INTRA_NONREF;
          o.expiry = 11'(gop);
        end else if (p % l1 == 0) begin
          o.sort = gopr_pkg::SORT_INTER_REF; o.cnt = 2'd1;
          o.ref0 = 32'(p - l1); o.expiry = 11'(2 * l1);
        end else if (p % l1 == l1 - 1) begin
          o.sort = gopr_pkg::SORT_INTER_NONREF; o.cnt = 2'd1;
          o.ref0 = 32'(p - 1); o.expiry = 11'd1;
          if (t.fwd) begin o.cnt = 2'd2; o.ref1 = 32'(p + 1); end
        end else begin
          o.sort = gopr_pkg::SORT_INTER_REF; o.cnt = 2'd1;
          o.ref0 = 32'(p - 1); o.expiry = 11'd2;
          if (t.fwd) begin o.cnt = 2'd2; o.ref1 = 32'((p / l1 + 1) * l1); end
        end
      end else begin
        if (f % gop == 0) begin
          if (gop > 1) begin
            o.sort = gopr_pkg::SORT_INTRA_REF; o.expiry = 11'(gop * 2);
            if (par != 0) begin
              o.sort = gopr_pkg::SORT_INTER_REF; o.cnt = 2'd1; o.ref0 = 32'(p - 1);
            end
          end else begin
            o.sort = gopr_pkg::SORT_INTRA_NONREF; o.expiry = 11'(gop);
          end
        end else if (f % l1 == 0) begin
          o.sort = gopr_pkg::SORT_INTER_REF; o.cnt = 2'd2;
          o.expiry = 11'((l1 + 1) * 2 - 1);
          if (par != 0) begin
            o.ref0 = 32'(p - 1); o.ref1 = 32'(p - 2 * l1);
          end else begin
            o.ref0 = 32'(p - 2 * l1); o.ref1 = 32'(p - 2 * l1 + 1);
          end
        end else if (f % l1 == l1 - 1) begin
          o.sort = gopr_pkg::SORT_INTER_NONREF; o.cnt = 2'd1;
          o.ref0 = 32'(p - 2); o.expiry = 11'd1;
          if (t.fwd) begin o.cnt = 2'd2; o.ref1 = 32'(p + 2); end
        end else begin
          o.sort = gopr_pkg::SORT_INTER_REF; o.cnt = 2'd1;
          o.ref0 = 32'(p - 2); o.expiry = 11'd4;
          if (t.fwd) begin o.cnt = 2'd2; o.ref1 = 32'(((f / l1 + 1) * l1) * 2 + par); end
        end
      end
    end else begin
      if (l1 == 0) d = p;
      else if (fld_mode == 0) begin
        if (p == 0) d = 0;
        else if ((p - 1) % l1 == 0) d = (p + l1 - 1) & 64'hFFFF_FFFF;
        else d = (p - 1) & 64'hFFFF_FFFF;
      end else begin
        if (f == 0) d = p;
        else if ((f - 1) % l1 == 0) d = (p + (l1 - 1) * 2) & 64'hFFFF_FFFF;
        else d = (p - 2) & 64'hFFFF_FFFF;
      end
      unit = (fld_mode != 0) ? gop * 2 : gop;
      o.disp = 32'(d);
      o.nau = (d % unit == 0);
    end
    return o;
  endfunction

  // request driver; expectations are formed at acceptance
  always @(posedge clk) begin
    pic_req_t t;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        t.cmd = req.cmd; t.num = req.picture_number; t.fwd = req.forward_ref_available;
        plan_queue = {plan_queue, plan_picture(t)};
      end
      if (!req.valid || req.ready) begin
        if (pic_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          t = pic_queue.pop_front();
          req.valid <= 1'b1;
          req.cmd <= t.cmd;
          req.picture_number <= t.num;
          req.forward_ref_available <= t.fwd;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_go && !hold_done) begin
      hold_cycles <= 200;
      hold_done <= 1'b1;
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    plan_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (plan_queue.size() == 0) begin
          $error("unexpected transaction on response channel");
          errors++;
        end else begin
          e = plan_queue.pop_front();
          if (rsp.picture_sort !== e.sort) begin
            $error("picture_sort exp %0d got %0d", e.sort, rsp.picture_sort); errors++;
          end
          if (rsp.ref_count !== e.cnt) begin
            $error("ref_count exp %0d got %0d", e.cnt, rsp.ref_count); errors++;
          end
          if (rsp.ref_first !== e.ref0) begin
            $error("ref_first exp %h got %h", e.ref0, rsp.ref_first); errors++;
          end
          if (rsp.ref_second !== e.ref1) begin
            $error("ref_second exp %h got %h", e.ref1, rsp.ref_second); errors++;
          end
          if (rsp.expiry_time !== e.expiry) begin
            $error("expiry_time exp %0d got %0d", e.expiry, rsp.expiry_time); errors++;
          end
          if (rsp.display_number !== e.disp) begin
            $error("display_number exp %h got %h", e.disp, rsp.display_number); errors++;
          end
          if (rsp.new_access_unit !== e.nau) begin
            $error("new_access_unit exp %0d got %0d", e.nau, rsp.new_access_unit);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(val);
    case (idx)
      gopr_pkg::REG_GOP_LENGTH: gop_len = val & 32'h3FF;
      gopr_pkg::REG_L1_SPACING: l1_sp = val & 32'hFF;
      gopr_pkg::REG_L1_ENABLED: l1_en = val & 32'h1;
      gopr_pkg::REG_FIELD_MODE: fld_mode = val & 32'h1;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned g, int unsigned s, int unsigned en, int unsigned fm);
    write_reg(gopr_pkg::REG_GOP_LENGTH, g);
    write_reg(gopr_pkg::REG_L1_SPACING, s);
    write_reg(gopr_pkg::REG_L1_ENABLED, en);
    write_reg(gopr_pkg::REG_FIELD_MODE, fm);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pic(logic cmd, logic [31:0] num, logic fwd);
    pic_req_t t;
    t.cmd = cmd; t.num = num; t.fwd = fwd;
    pic_queue = {pic_queue, t};
  endtask

  task automatic add_random(int n);
    int unsigned kind;
    logic [31:0] num;
    repeat (n) begin
      kind = $urandom_range(9);
      if (kind < 5) num = $urandom_range(3000);
      else if (kind < 7) num = 32'hFFFF_FFFF - $urandom_range(600);
      else num = $urandom;
      add_pic($urandom_range(1) ? gopr_pkg::CMD_MAP : gopr_pkg::CMD_CLASSIFY, num,
              1'($urandom_range(1)));
    end
  endtask

  task automatic drain();
    while (pic_queue.size() > 0 || req.valid || plan_queue.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int unsigned settings[11][4];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    gop_len = 1; l1_sp = 0; l1_en = 0; fld_mode = 0;
    settings = '{'{8, 3, 1, 0}, '{8, 3, 1, 1}, '{1023, 255, 1, 0}, '{1023, 255, 1, 1},
                 '{0, 1, 1, 0}, '{12, 4, 1, 1}, '{5, 0, 1, 1}, '{30, 2, 0, 0},
                 '{1, 1, 1, 1}, '{16, 7, 1, 0}, '{6, 2, 1, 1}};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, then directed corners under a mid-range setting
    add_random(20);
    drain();
    configure(8, 3, 1, 0);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'd0, 1'b1);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'd1, 1'b1);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'd2, 1'b1);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'd2, 1'b0);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'd3, 1'b0);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'd5, 1'b1);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'hFFFF_FFFF, 1'b1);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'hFFFF_FFFE, 1'b1);
    add_pic(gopr_pkg::CMD_CLASSIFY, 32'h8000_0000, 1'b0);
    add_pic(gopr_pkg::CMD_MAP, 32'd0, 1'b0);
    add_pic(gopr_pkg::CMD_MAP, 32'd1, 1'b1);
    add_pic(gopr_pkg::CMD_MAP, 32'd2, 1'b0);
    add_pic(gopr_pkg::CMD_MAP, 32'd4, 1'b0);
    add_pic(gopr_pkg::CMD_MAP, 32'hFFFF_FFFF, 1'b0);
    add_pic(gopr_pkg::CMD_MAP, 32'hFFFF_FFFE, 1'b1);
    add_pic(gopr_pkg::CMD_MAP, 32'hAAAA_5555, 1'b1);
    drain();

    foreach (settings[i]) begin
      configure(settings[i][0], settings[i][1], settings[i][2], settings[i][3]);
      case (i % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      if (i == 4) hold_go = 1'b1;
      add_random(38);
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
